>>> rtl/core/rtc_pkg.sv
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types, constants and helpers of the roaster temperature controller.
// ----------------------------------------------------------------------------
package rtc_pkg;

  // widths of the configuration port
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  // register byte addresses
  localparam logic [AddrWidth-1:0] AddrGain     = 3'd0;
  localparam logic [AddrWidth-1:0] AddrDuration = 3'd4;

  // register reset values
  localparam logic [7:0]  GainReset     = 8'd12;
  localparam logic [15:0] DurationReset = 16'd1200;

  // state reset values
  localparam logic [9:0] SetpointReset = 10'd450;
  localparam logic [9:0] FanReset      = 10'd50;
  localparam logic [7:0] DriveMin      = 8'd160;

  // arithmetic constants
  localparam logic [15:0] Div5Mult     = 16'd52429;  // ceil(2^18 / 5)
  localparam logic [15:0] TempOffset   = 16'd160;    // 320 / 2 after halving by 10 -> 5
  localparam logic [9:0]  DemandLimit  = 10'd1000;
  localparam logic [13:0] DriveScale   = 14'd10488;  // 4 * ceil(2^16 / 25)
  localparam logic [10:0] DrumOffset   = 11'd373;    // 746 / 2
  localparam logic [7:0]  FanFull      = 8'd160;

  // configuration registers
  typedef struct packed {
    logic [7:0]  gain;
    logic [15:0] duration;
  } cfg_t;

  // one accepted input word
  typedef struct packed {
    logic       mode;
    logic [7:0] tc_high;
    logic [7:0] tc_low;
    logic       control_due;
    logic       second_tick;
    logic       cooling_second;
    logic [7:0] cmd0;
    logic [7:0] cmd1;
    logic [7:0] cmd2;
    logic [7:0] cmd3;
  } in_item_t;

  // word after temperature conversion
  typedef struct packed {
    logic        mode;
    logic [12:0] temp;
    logic        control_due;
    logic        second_tick;
    logic        cooling_second;
    logic [7:0]  cmd0;
    logic [7:0]  cmd1;
    logic [7:0]  cmd2;
    logic [7:0]  cmd3;
  } conv_t;

  // word after the control state update
  typedef struct packed {
    logic [12:0] temp;
    logic        drive_upd;
    logic [9:0]  demand;
    logic        heater;
    logic        exhaust;
    logic        overtemp;
    logic [9:0]  fan;
    logic [9:0]  drum;
    logic        drum_on;
    logic        cooling;
    logic        finished;
    logic [15:0] elapsed;
    logic [15:0] crack;
  } snap_t;

  // result word
  typedef struct packed {
    logic [12:0] temp;
    logic        heater;
    logic        exhaust;
    logic        overtemp;
    logic [7:0]  fan_timer;
    logic [9:0]  drum_pwm;
    logic        drum_on;
    logic        cooling;
    logic        finished;
    logic [15:0] elapsed;
    logic [15:0] crack;
  } result_t;

  // exact x / 5 for any 16-bit x below 40960, where the quotient fits in 13 bits
  function automatic logic [12:0] div_by_5(input logic [15:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'(Div5Mult);
    return prod[30:18];
  endfunction

endpackage

>>> rtl/core/rtc_cfg.sv
// ----------------------------------------------------------------------------
// rtc_cfg
// APB-style register file holding the gain and the roast duration.
// ----------------------------------------------------------------------------
module rtc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rtc_pkg::AddrWidth-1:0] paddr,
  input  logic [rtc_pkg::DataWidth-1:0] pwdata,
  output logic [rtc_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  output rtc_pkg::cfg_t                 cfg_o
);
  import rtc_pkg::*;

  logic [7:0]  gain_q;
  logic [15:0] duration_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // register writes, decoded on the word address bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= GainReset;
      duration_q <= DurationReset;
    end else if (wr_en) begin
      if (paddr[2] == AddrDuration[2]) begin
        duration_q <= pwdata[15:0];
      end else begin
        gain_q <= pwdata[7:0];
      end
    end
  end

  // read mux
  always_comb begin
    if (paddr[2] == AddrDuration[2]) begin
      prdata = {16'd0, duration_q};
    end else begin
      prdata = {24'd0, gain_q};
    end
  end

  assign cfg_o.gain     = gain_q;
  assign cfg_o.duration = duration_q;

endmodule

>>> rtl/core/rtc_conv.sv
// ----------------------------------------------------------------------------
// rtc_conv
// Input register and thermocouple to Fahrenheit conversion stage.
// ----------------------------------------------------------------------------
module rtc_conv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  rtc_pkg::in_item_t item_i,
  output logic              valid_o,
  input  logic              ready_i,
  output rtc_pkg::conv_t    conv_o
);
  import rtc_pkg::*;

  logic        in_valid_q;
  in_item_t    item_q;
  logic        conv_valid_q;
  conv_t       conv_q;
  logic        in_ready;
  logic        conv_ready;
  logic [11:0] celsius;
  logic [15:0] scaled;
  conv_t       conv_d;

  // bubble-collapsing handshake over the two registers
  assign conv_ready = ~conv_valid_q | ready_i;
  assign in_ready   = ~in_valid_q | conv_ready;
  assign ready_o    = in_ready;

  // F = (C*18 + 320) / 10 = (C*9 + 160) / 5
  assign celsius = {item_q.tc_high, item_q.tc_low[7:4]};
  assign scaled  = 16'({celsius, 3'b000}) + 16'(celsius) + TempOffset;

  always_comb begin
    conv_d.mode           = item_q.mode;
    conv_d.temp           = div_by_5(scaled);
    conv_d.control_due    = item_q.control_due;
    conv_d.second_tick    = item_q.second_tick;
    conv_d.cooling_second = item_q.cooling_second;
    conv_d.cmd0           = item_q.cmd0;
    conv_d.cmd1           = item_q.cmd1;
    conv_d.cmd2           = item_q.cmd2;
    conv_d.cmd3           = item_q.cmd3;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      conv_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= valid_i;
      end
      if (conv_ready) begin
        conv_valid_q <= in_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready && valid_i) begin
      item_q <= item_i;
    end
    if (conv_ready && in_valid_q) begin
      conv_q <= conv_d;
    end
  end

  assign valid_o = conv_valid_q;
  assign conv_o  = conv_q;

endmodule

>>> rtl/core/rtc_ctrl.sv
// ----------------------------------------------------------------------------
// rtc_ctrl
// Control state update: setpoint compare, demand, roast clock and commands.
// ----------------------------------------------------------------------------
module rtc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rtc_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  rtc_pkg::conv_t conv_i,
  output logic           valid_o,
  input  logic           ready_i,
  output rtc_pkg::snap_t snap_o
);
  import rtc_pkg::*;

  typedef enum logic [3:0] {
    CmdNone,
    CmdCool,
    CmdZero,
    CmdCrack,
    CmdDrumOn,
    CmdDrumOff,
    CmdSetpoint,
    CmdFan,
    CmdDrum
  } cmd_e;

  // ascii codes
  localparam logic [7:0] ChX = 8'h58;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChO = 8'h4f;
  localparam logic [7:0] ChL = 8'h4c;
  localparam logic [7:0] ChZ = 8'h5a;
  localparam logic [7:0] ChE = 8'h45;
  localparam logic [7:0] ChR = 8'h52;
  localparam logic [7:0] ChF = 8'h46;
  localparam logic [7:0] ChN = 8'h4e;
  localparam logic [7:0] ChS = 8'h53;
  localparam logic [7:0] ChD = 8'h44;
  localparam logic [7:0] Ch0 = 8'h30;
  localparam logic [7:0] Ch9 = 8'h39;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= Ch0) && (b <= Ch9);
  endfunction

  // decimal value of up to three digits, stopping at the first non-digit
  function automatic logic [9:0] parse_digits(input logic [7:0] b1, input logic [7:0] b2,
                                              input logic [7:0] b3);
    logic [3:0] n1;
    logic [3:0] n2;
    logic [3:0] n3;
    logic [9:0] v;
    n1 = 4'(b1 - Ch0);
    n2 = 4'(b2 - Ch0);
    n3 = 4'(b3 - Ch0);
    if (!is_digit(b1)) begin
      v = 10'd0;
    end else if (!is_digit(b2)) begin
      v = 10'(n1);
    end else if (!is_digit(b3)) begin
      v = 10'(n1) * 10'd10 + 10'(n2);
    end else begin
      v = 10'(n1) * 10'd100 + 10'(n2) * 10'd10 + 10'(n3);
    end
    return v;
  endfunction

  logic [9:0]  setpoint_q, setpoint_d;
  logic [9:0]  fan_q, fan_d;
  logic [9:0]  drum_q, drum_d;
  logic        drum_on_q, drum_on_d;
  logic        cooling_q, cooling_d;
  logic        finished_q, finished_d;
  logic        overtemp_q, overtemp_d;
  logic        heater_q, heater_d;
  logic        exhaust_q, exhaust_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] crack_q, crack_d;
  logic        snap_valid_q;
  snap_t       snap_q;
  snap_t       snap_d;
  logic        fire;
  logic        drive_upd;
  cmd_e        cmd;
  logic [9:0]  digits;
  logic [9:0]  error;
  logic [17:0] product;
  logic [9:0]  demand;
  logic        above;
  logic        below;

  assign ready_o = ~snap_valid_q | ready_i;
  assign fire    = valid_i & ready_o;

  // command decode
  always_comb begin
    cmd = CmdNone;
    if (conv_i.cmd0 == ChX) begin
      if (conv_i.cmd1 == ChC && conv_i.cmd2 == ChO && conv_i.cmd3 == ChL) begin
        cmd = CmdCool;
      end else if (conv_i.cmd1 == ChZ && conv_i.cmd2 == ChE && conv_i.cmd3 == ChR) begin
        cmd = CmdZero;
      end else if (conv_i.cmd1 == ChF && conv_i.cmd2 == ChC && conv_i.cmd3 == ChZ) begin
        cmd = CmdCrack;
      end else if (conv_i.cmd1 == ChR && conv_i.cmd2 == ChO && conv_i.cmd3 == ChN) begin
        cmd = CmdDrumOn;
      end else if (conv_i.cmd1 == ChR && conv_i.cmd2 == ChO && conv_i.cmd3 == ChF) begin
        cmd = CmdDrumOff;
      end
    end else if (conv_i.cmd0 == ChS) begin
      cmd = CmdSetpoint;
    end else if (conv_i.cmd0 == ChF) begin
      cmd = CmdFan;
    end else if (conv_i.cmd0 == ChD) begin
      cmd = CmdDrum;
    end
  end

  assign digits = parse_digits(conv_i.cmd1, conv_i.cmd2, conv_i.cmd3);

  // setpoint compare and clamped proportional demand
  assign above   = conv_i.temp > 13'(setpoint_q);
  assign below   = conv_i.temp < 13'(setpoint_q);
  assign error   = setpoint_q - conv_i.temp[9:0];
  assign product = 18'(error) * 18'(cfg_i.gain);
  assign demand  = (product > 18'(DemandLimit)) ? DemandLimit : product[9:0];

  // next state
  always_comb begin
    setpoint_d = setpoint_q;
    fan_d      = fan_q;
    drum_d     = drum_q;
    drum_on_d  = drum_on_q;
    cooling_d  = cooling_q;
    finished_d = finished_q;
    overtemp_d = overtemp_q;
    heater_d   = heater_q;
    exhaust_d  = exhaust_q;
    elapsed_d  = elapsed_q;
    crack_d    = crack_q;
    drive_upd  = 1'b0;
    if (conv_i.mode) begin
      unique case (cmd)
        CmdCool:     cooling_d  = 1'b1;
        CmdZero:     elapsed_d  = 16'd0;
        CmdCrack: begin
          crack_d   = elapsed_q;
          elapsed_d = 16'd0;
        end
        CmdDrumOn:   drum_on_d  = 1'b1;
        CmdDrumOff:  drum_on_d  = 1'b0;
        CmdSetpoint: setpoint_d = digits;
        CmdFan:      fan_d      = digits;
        CmdDrum:     drum_d     = digits;
        default: ;
      endcase
    end else begin
      if (conv_i.second_tick) begin
        elapsed_d = elapsed_q + 16'd1;
      end
      if (above) begin
        overtemp_d = 1'b1;
        heater_d   = 1'b0;
        exhaust_d  = 1'b1;
      end else if (below) begin
        exhaust_d  = 1'b0;
        overtemp_d = 1'b0;
        drive_upd  = conv_i.control_due;
      end
      if (elapsed_d == cfg_i.duration) begin
        heater_d = 1'b1;
      end
      if (cooling_q && conv_i.cooling_second) begin
        heater_d   = 1'b1;
        finished_d = 1'b1;
      end
    end
  end

  // snapshot handed to the output stage
  always_comb begin
    snap_d.temp      = conv_i.mode ? 13'd0 : conv_i.temp;
    snap_d.drive_upd = drive_upd;
    snap_d.demand    = demand;
    snap_d.heater    = heater_d;
    snap_d.exhaust   = exhaust_d;
    snap_d.overtemp  = overtemp_d;
    snap_d.fan       = fan_d;
    snap_d.drum      = drum_d;
    snap_d.drum_on   = drum_on_d;
    snap_d.cooling   = cooling_d;
    snap_d.finished  = finished_d;
    snap_d.elapsed   = elapsed_d;
    snap_d.crack     = crack_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q   <= SetpointReset;
      fan_q        <= FanReset;
      drum_q       <= 10'd0;
      drum_on_q    <= 1'b0;
      cooling_q    <= 1'b0;
      finished_q   <= 1'b0;
      overtemp_q   <= 1'b0;
      heater_q     <= 1'b0;
      exhaust_q    <= 1'b0;
      elapsed_q    <= 16'd0;
      crack_q      <= 16'd0;
      snap_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        setpoint_q <= setpoint_d;
        fan_q      <= fan_d;
        drum_q     <= drum_d;
        drum_on_q  <= drum_on_d;
        cooling_q  <= cooling_d;
        finished_q <= finished_d;
        overtemp_q <= overtemp_d;
        heater_q   <= heater_d;
        exhaust_q  <= exhaust_d;
        elapsed_q  <= elapsed_d;
        crack_q    <= crack_d;
      end
      if (ready_o) begin
        snap_valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      snap_q <= snap_d;
    end
  end

  assign valid_o = snap_valid_q;
  assign snap_o  = snap_q;

endmodule

>>> rtl/core/rtc_out.sv
// ----------------------------------------------------------------------------
// rtc_out
// Heater drive mapping, fan and drum scaling, and the result register.
// ----------------------------------------------------------------------------
module rtc_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  rtc_pkg::snap_t   snap_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [7:0]       drive_o,
  output rtc_pkg::result_t result_o
);
  import rtc_pkg::*;

  logic        out_valid_q;
  logic [7:0]  drive_q, drive_d;
  result_t     result_q;
  result_t     result_d;
  logic        fire;
  logic [23:0] drive_prod;
  logic [10:0] drum_sum;
  logic [12:0] drum_quot;

  assign ready_o = ~out_valid_q | ready_i;
  assign fire    = valid_i & ready_o;

  // drive = 160 - (demand * 16) / 100, exact for demand up to 1000
  assign drive_prod = 24'(snap_i.demand) * 24'(DriveScale);
  assign drive_d    = snap_i.drive_upd ? (DriveMin - drive_prod[23:16]) : drive_q;

  // drum duty = (speed * 2 + 746) / 10 = (speed + 373) / 5
  assign drum_sum  = 11'(snap_i.drum) + DrumOffset;
  assign drum_quot = div_by_5(16'(drum_sum));

  always_comb begin
    result_d.temp      = snap_i.temp;
    result_d.heater    = snap_i.heater;
    result_d.exhaust   = snap_i.exhaust;
    result_d.overtemp  = snap_i.overtemp;
    result_d.fan_timer = (snap_i.fan > 10'(FanFull)) ? 8'd0 : 8'(10'(FanFull) - snap_i.fan);
    result_d.drum_pwm  = drum_quot[9:0];
    result_d.drum_on   = snap_i.drum_on;
    result_d.cooling   = snap_i.cooling;
    result_d.finished  = snap_i.finished;
    result_d.elapsed   = snap_i.elapsed;
    result_d.crack     = snap_i.crack;
  end

  // drive state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q     <= DriveMin;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        drive_q <= drive_d;
      end
      if (ready_o) begin
        out_valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign drive_o  = drive_q;
  assign result_o = result_q;

endmodule

>>> rtl/core/roaster_temperature_controller_core.sv
// ----------------------------------------------------------------------------
// roaster_temperature_controller_core
// Roaster heater, exhaust, drum and roast clock controller.
// ----------------------------------------------------------------------------
// Takes one word per cycle while in_ready_o is high and returns one result
// word per input word, in order. The pipeline has four registers: input,
// converted temperature, control state update and result; each stage holds
// its word only while the next one is full, so stalls on the output side are
// absorbed one word per stage. All control state (setpoint, flags, roast
// clock, drive value) is updated once per word, so consecutive words see
// each other's effects exactly.
// No memories and no start-up pass: words are accepted from the first cycle
// after reset. Gain and roast duration are written over the APB port at byte
// addresses 0 and 4 and must only be changed while no word is in flight.
module roaster_temperature_controller_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [7:0]                    tc_high_i,
  input  logic [7:0]                    tc_low_i,
  input  logic                          control_due_i,
  input  logic                          second_tick_i,
  input  logic                          cooling_second_i,
  input  logic [7:0]                    cmd_byte0_i,
  input  logic [7:0]                    cmd_byte1_i,
  input  logic [7:0]                    cmd_byte2_i,
  input  logic [7:0]                    cmd_byte3_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [12:0]                   temp_fahrenheit_o,
  output logic [7:0]                    heater_drive_o,
  output logic                          heater_pin_o,
  output logic                          exhaust_fan_o,
  output logic                          overtemp_o,
  output logic [7:0]                    fan_timer_o,
  output logic [9:0]                    drum_pwm_o,
  output logic                          drum_enable_o,
  output logic                          cooling_mode_o,
  output logic                          roast_finished_o,
  output logic [15:0]                   elapsed_seconds_o,
  output logic [15:0]                   first_crack_seconds_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rtc_pkg::AddrWidth-1:0] paddr,
  input  logic [rtc_pkg::DataWidth-1:0] pwdata,
  output logic [rtc_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);
  import rtc_pkg::*;

  cfg_t     cfg;
  in_item_t item;
  conv_t    conv;
  snap_t    snap;
  result_t  result;
  logic     conv_valid;
  logic     conv_ready;
  logic     snap_valid;
  logic     snap_ready;

  // configuration registers
  rtc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input word
  always_comb begin
    item.mode           = mode_i;
    item.tc_high        = tc_high_i;
    item.tc_low         = tc_low_i;
    item.control_due    = control_due_i;
    item.second_tick    = second_tick_i;
    item.cooling_second = cooling_second_i;
    item.cmd0           = cmd_byte0_i;
    item.cmd1           = cmd_byte1_i;
    item.cmd2           = cmd_byte2_i;
    item.cmd3           = cmd_byte3_i;
  end

  // temperature conversion
  rtc_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (item),
    .valid_o (conv_valid),
    .ready_i (conv_ready),
    .conv_o  (conv)
  );

  // control state
  rtc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (conv_valid),
    .ready_o (conv_ready),
    .conv_i  (conv),
    .valid_o (snap_valid),
    .ready_i (snap_ready),
    .snap_o  (snap)
  );

  // drive mapping and result register
  rtc_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (snap_valid),
    .ready_o  (snap_ready),
    .snap_i   (snap),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .drive_o  (heater_drive_o),
    .result_o (result)
  );

  assign temp_fahrenheit_o     = result.temp;
  assign heater_pin_o          = result.heater;
  assign exhaust_fan_o         = result.exhaust;
  assign overtemp_o            = result.overtemp;
  assign fan_timer_o           = result.fan_timer;
  assign drum_pwm_o            = result.drum_pwm;
  assign drum_enable_o         = result.drum_on;
  assign cooling_mode_o        = result.cooling;
  assign roast_finished_o      = result.finished;
  assign elapsed_seconds_o     = result.elapsed;
  assign first_crack_seconds_o = result.crack;

endmodule

>>> rtl/core/rtc_checker.sv
// ----------------------------------------------------------------------------
// rtc_checker
// Port-level checks on the result channel of the roaster controller.
// ----------------------------------------------------------------------------
module rtc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [12:0] temp_fahrenheit_o,
  input logic [7:0]  heater_drive_o,
  input logic        exhaust_fan_o,
  input logic        overtemp_o,
  input logic [7:0]  fan_timer_o,
  input logic        cooling_mode_o,
  input logic        roast_finished_o,
  input logic [15:0] elapsed_seconds_o
);
  import rtc_pkg::*;

  // a stalled result keeps its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(temp_fahrenheit_o) &&
      $stable(heater_drive_o) && $stable(elapsed_seconds_o))
    else $error("result changed while stalled");

  // phase drive never goes past minimum heat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heater_drive_o <= DriveMin)
    else $error("heater drive out of range");

  // exhaust follows the over-temperature flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> exhaust_fan_o == overtemp_o)
    else $error("exhaust and overtemp disagree");

  // a roast only finishes in cooling mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && roast_finished_o |-> cooling_mode_o)
    else $error("finished without cooling");

  // fan timer saturates within its range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fan_timer_o <= FanFull)
    else $error("fan timer out of range");

endmodule

bind roaster_temperature_controller_core rtc_checker u_rtc_checker (.*);

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the roaster temperature controller core. Sensor
// and command words go in over a valid/ready channel with bursty gaps, and
// results are taken under a shifting stall pattern. A predictor of the
// controller state works out every result word, and each one is compared
// field by field. Gain and roast duration are changed over APB between
// phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // word modes and command codes
  localparam logic        ModeSample  = 1'b0;
  localparam logic        ModeCommand = 1'b1;
  localparam logic [31:0] CmdCool     = "XCOL";
  localparam logic [31:0] CmdZero     = "XZER";
  localparam logic [31:0] CmdCrack    = "XFCZ";
  localparam logic [31:0] CmdDrumOn   = "XRON";
  localparam logic [31:0] CmdDrumOff  = "XROF";
  localparam logic [7:0]  ChSet       = "S";
  localparam logic [7:0]  ChFan       = "F";
  localparam logic [7:0]  ChDrum      = "D";
  localparam logic [7:0]  ChX         = "X";
  localparam logic [7:0]  ChZero      = "0";
  localparam logic [7:0]  ChNine      = "9";

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 8;

  // one expected result word
  typedef struct packed {
    logic [12:0] temp;
    logic [7:0]  drive;
    logic        heater;
    logic        exhaust;
    logic        overtemp;
    logic [7:0]  fan_timer;
    logic [9:0]  drum_pwm;
    logic        drum_on;
    logic        cooling;
    logic        finished;
    logic [15:0] elapsed;
    logic [15:0] crack;
  } reading_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        mode;
  logic [7:0]  tc_high;
  logic [7:0]  tc_low;
  logic        control_due;
  logic        second_tick;
  logic        cooling_second;
  logic [7:0]  cmd0;
  logic [7:0]  cmd1;
  logic [7:0]  cmd2;
  logic [7:0]  cmd3;
  logic        out_valid;
  logic        out_ready;
  logic [12:0] temp_f;
  logic [7:0]  heater_drive;
  logic        heater_pin;
  logic        exhaust_fan;
  logic        overtemp;
  logic [7:0]  fan_timer;
  logic [9:0]  drum_pwm;
  logic        drum_enable;
  logic        cooling_mode;
  logic        roast_finished;
  logic [15:0] elapsed_seconds;
  logic [15:0] first_crack_seconds;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [rtc_pkg::AddrWidth-1:0] paddr;
  logic [rtc_pkg::DataWidth-1:0] pwdata;
  logic [rtc_pkg::DataWidth-1:0] prdata;
  logic        pready;

  // predicted controller state and registers
  logic [7:0]  gain_q;
  logic [15:0] duration_q;
  int unsigned setpoint_q;
  int unsigned fan_pct_q;
  int unsigned drum_speed_q;
  logic        drum_run_q;
  logic        cool_q;
  logic        done_q;
  logic        over_q;
  logic        heat_q;
  logic        exhaust_q;
  logic [7:0]  drive_q;
  logic [15:0] elapsed_q;
  logic [15:0] crack_q;

  reading_t    pending_readings[$];
  int unsigned mismatches;
  int unsigned burst_left;
  reading_t    want_r;

  roaster_temperature_controller_core u_dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .mode_i                (mode),
    .tc_high_i             (tc_high),
    .tc_low_i              (tc_low),
    .control_due_i         (control_due),
    .second_tick_i         (second_tick),
    .cooling_second_i      (cooling_second),
    .cmd_byte0_i           (cmd0),
    .cmd_byte1_i           (cmd1),
    .cmd_byte2_i           (cmd2),
    .cmd_byte3_i           (cmd3),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .temp_fahrenheit_o     (temp_f),
    .heater_drive_o        (heater_drive),
    .heater_pin_o          (heater_pin),
    .exhaust_fan_o         (exhaust_fan),
    .overtemp_o            (overtemp),
    .fan_timer_o           (fan_timer),
    .drum_pwm_o            (drum_pwm),
    .drum_enable_o         (drum_enable),
    .cooling_mode_o        (cooling_mode),
    .roast_finished_o      (roast_finished),
    .elapsed_seconds_o     (elapsed_seconds),
    .first_crack_seconds_o (first_crack_seconds),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // decimal value of bytes 1..3, stopping at the first non-digit
  function automatic int unsigned parse_number(rtc_pkg::in_item_t w);
    logic [7:0]  b [3];
    int unsigned v;
    logic        stop;
    b[0] = w.cmd1;
    b[1] = w.cmd2;
    b[2] = w.cmd3;
    v    = 0;
    stop = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (b[i] < ChZero || b[i] > ChNine) stop = 1'b1;
      if (!stop) v = v * 10 + (b[i] - ChZero);
    end
    return v;
  endfunction

  // controller state update for one word, returns the result it must give
  function automatic reading_t advance_controller(rtc_pkg::in_item_t w);
    reading_t    r;
    int unsigned celsius;
    int unsigned temp;
    int unsigned demand;
    logic [31:0] text;
    temp = 0;
    if (w.mode == ModeCommand) begin
      text = {w.cmd0, w.cmd1, w.cmd2, w.cmd3};
      if (text == CmdCool) begin
        cool_q = 1'b1;
      end else if (text == CmdZero) begin
        elapsed_q = '0;
      end else if (text == CmdCrack) begin
        crack_q   = elapsed_q;
        elapsed_q = '0;
      end else if (text == CmdDrumOn) begin
        drum_run_q = 1'b1;
      end else if (text == CmdDrumOff) begin
        drum_run_q = 1'b0;
      end else if (w.cmd0 == ChSet) begin
        setpoint_q = parse_number(w);
      end else if (w.cmd0 == ChFan) begin
        fan_pct_q = parse_number(w);
      end else if (w.cmd0 == ChDrum) begin
        drum_speed_q = parse_number(w);
      end
    end else begin
      // shift out the flag nibble, then celsius to fahrenheit
      celsius = {w.tc_high, w.tc_low} >> 4;
      temp    = (celsius * 18 + 320) / 10;
      if (temp > 8191) temp = 8191;
      if (w.second_tick) elapsed_q = elapsed_q + 16'd1;
      if (temp > setpoint_q) begin
        over_q    = 1'b1;
        heat_q    = 1'b0;
        exhaust_q = 1'b1;
      end else if (temp < setpoint_q) begin
        exhaust_q = 1'b0;
        over_q    = 1'b0;
        if (w.control_due) begin
          demand = (setpoint_q - temp) * gain_q;
          if (demand > 1000) demand = 1000;
          drive_q = 8'(160 - (demand * 16) / 100);
        end
      end
      if (elapsed_q == duration_q) heat_q = 1'b1;
      if (cool_q && w.cooling_second) begin
        heat_q = 1'b1;
        done_q = 1'b1;
      end
    end
    r.temp      = 13'(temp);
    r.drive     = drive_q;
    r.heater    = heat_q;
    r.exhaust   = exhaust_q;
    r.overtemp  = over_q;
    r.fan_timer = (fan_pct_q > 160) ? 8'd0 : 8'(160 - fan_pct_q);
    r.drum_pwm  = 10'((drum_speed_q * 2 + 746) / 10);
    r.drum_on   = drum_run_q;
    r.cooling   = cool_q;
    r.finished  = done_q;
    r.elapsed   = elapsed_q;
    r.crack     = crack_q;
    return r;
  endfunction

  // sensor word, command bytes random since they are ignored
  function automatic rtc_pkg::in_item_t sample_word(logic [15:0] raw, logic due, logic tick,
                                                    logic cool);
    rtc_pkg::in_item_t w;
    w                = '0;
    w.mode           = ModeSample;
    {w.tc_high, w.tc_low} = raw;
    w.control_due    = due;
    w.second_tick    = tick;
    w.cooling_second = cool;
    {w.cmd0, w.cmd1, w.cmd2, w.cmd3} = $urandom;
    return w;
  endfunction

  // command word, sensor bytes and flags random since they are ignored
  function automatic rtc_pkg::in_item_t command_word(logic [31:0] text);
    rtc_pkg::in_item_t w;
    w                = '0;
    w.mode           = ModeCommand;
    {w.cmd0, w.cmd1, w.cmd2, w.cmd3} = text;
    {w.tc_high, w.tc_low} = 16'($urandom);
    w.control_due    = 1'($urandom);
    w.second_tick    = 1'($urandom);
    w.cooling_second = 1'($urandom);
    return w;
  endfunction

  // random word, mostly meaningful commands and samples near the setpoint
  function automatic rtc_pkg::in_item_t random_word(logic allow_cool);
    int unsigned target;
    int unsigned celsius;
    logic [15:0] raw;
    logic [7:0]  d0;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [7:0]  lead;
    d0 = 8'(ChZero + $urandom_range(0, 9));
    d1 = 8'(ChZero + $urandom_range(0, 9));
    d2 = 8'(ChZero + $urandom_range(0, 9));
    case ($urandom_range(0, 2))
      0: lead = ChSet;
      1: lead = ChFan;
      default: lead = ChDrum;
    endcase
    if ($urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          // within 30 degrees of the setpoint, clamped at 32
          target = setpoint_q + $urandom_range(0, 60);
          target = (target > 30) ? target - 30 : 0;
          if (target < 32) target = 32;
          celsius = (target * 10 - 320 + $urandom_range(0, 17)) / 18;
          if (celsius > 4095) celsius = 4095;
          raw = {celsius[11:0], 4'($urandom)};
        end
        2: raw = 16'($urandom);
        default: raw = 16'($urandom_range(0, 16'h1fff));
      endcase
      return sample_word(raw, 1'($urandom), 1'($urandom), $urandom_range(0, 3) == 0);
    end
    case ($urandom_range(0, allow_cool ? 11 : 10))
      0: return command_word(CmdZero);
      1: return command_word(CmdCrack);
      2: return command_word(CmdDrumOn);
      3: return command_word(CmdDrumOff);
      4, 5: return command_word({ChSet, d0, d1, d2});
      6: return command_word({ChFan, d0, d1, d2});
      7: return command_word({ChDrum, d0, d1, d2});
      8: return command_word({lead, d0, 8'($urandom), 8'($urandom)});
      9: return command_word($urandom);
      10: return command_word({ChX, 24'($urandom)});
      default: return command_word(CmdCool);
    endcase
  endfunction

  // send one word in bursts with random gaps, predict on acceptance
  task automatic send_word(input rtc_pkg::in_item_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid       <= 1'b1;
    mode           <= w.mode;
    tc_high        <= w.tc_high;
    tc_low         <= w.tc_low;
    control_due    <= w.control_due;
    second_tick    <= w.second_tick;
    cooling_second <= w.cooling_second;
    cmd0           <= w.cmd0;
    cmd1           <= w.cmd1;
    cmd2           <= w.cmd2;
    cmd3           <= w.cmd3;
    do @(posedge clk); while (!in_ready);
    pending_readings.push_back(advance_controller(w));
  endtask

  // hold off until every expected word has come back
  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  // apb write: setup then access, register written at the access edge
  task automatic write_register(input logic [rtc_pkg::AddrWidth-1:0] addr,
                                input logic [rtc_pkg::DataWidth-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (addr == rtc_pkg::AddrGain) gain_q = value[7:0];
    else if (addr == rtc_pkg::AddrDuration) duration_q = value[15:0];
  endtask

  task automatic set_registers(input logic [7:0] gain, input logic [15:0] duration);
    wait_drained();
    write_register(rtc_pkg::AddrGain, 32'(gain));
    write_register(rtc_pkg::AddrDuration, 32'(duration));
  endtask

  // sensor byte extremes, flag nibble, cooling second outside cooling mode
  task automatic test_sensor_extremes();
    send_word(sample_word(16'h0000, 1'b1, 1'b0, 1'b1));
    send_word(sample_word(16'hffff, 1'b1, 1'b1, 1'b1));
    send_word(sample_word(16'h000f, 1'b0, 1'b0, 1'b0));
    send_word(sample_word(16'h8000, 1'b1, 1'b1, 1'b0));
  endtask

  // every command but cooling, digit parse corners, sample equal to the setpoint
  task automatic test_command_decode();
    send_word(command_word(CmdDrumOn));
    send_word(command_word(CmdDrumOff));
    send_word(command_word(CmdDrumOn));
    send_word(command_word({ChDrum, "999"}));
    send_word(command_word({ChFan, "999"}));
    send_word(command_word({ChFan, "160"}));
    send_word(command_word({ChFan, "000"}));
    send_word(command_word({ChSet, "9A5"}));
    send_word(command_word({ChSet, "+12"}));
    send_word(command_word({ChDrum, " 12"}));
    send_word(command_word({ChX, "QQQ"}));
    send_word(command_word({ChSet, "032"}));
    send_word(sample_word(16'h0000, 1'b1, 1'b1, 1'b0));
    send_word(sample_word(16'h0005, 1'b1, 1'b1, 1'b0));
    send_word(command_word(CmdCrack));
    send_word(sample_word(16'h0000, 1'b0, 1'b1, 1'b0));
    send_word(command_word(CmdZero));
    send_word(command_word({ChSet, "450"}));
  endtask

  // random traffic under several gain and roast duration settings
  task automatic test_random_phases();
    logic [7:0]  gain;
    logic [15:0] duration;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gain = 8'd0;   duration = 16'd0;     end
        1: begin gain = 8'd255; duration = 16'hffff;  end
        2: begin gain = 8'($urandom_range(1, 254)); duration = 16'($urandom_range(1, 12)); end
        default: begin
          gain     = rtc_pkg::GainReset;
          duration = 16'($urandom_range(1, 12));
        end
      endcase
      set_registers(gain, duration);
      for (int n = 0; n < 100; n++) begin
        // one pause mid phase with the pipeline emptied
        if (n == 50) wait_drained();
        send_word(random_word(1'b0));
      end
    end
  endtask

  // roast clock meets a reachable duration, then the smallest duration
  task automatic test_clock_duration();
    rtc_pkg::in_item_t w;
    set_registers(8'($urandom_range(1, 40)), 16'd20);
    send_word(command_word(CmdZero));
    for (int n = 0; n < 40; n++) begin
      w = random_word(1'b0);
      if (w.mode == ModeCommand) w = sample_word(16'($urandom), 1'($urandom), 1'b1, 1'($urandom));
      w.second_tick = 1'b1;
      send_word(w);
    end
    set_registers(gain_q, 16'd0);
    send_word(sample_word(16'($urandom), 1'b1, 1'b0, 1'b1));
  endtask

  // cooling mode stays set until reset, so it is exercised last
  task automatic test_cooling();
    set_registers(8'($urandom_range(0, 255)), 16'($urandom_range(1, 12)));
    send_word(sample_word(16'h0000, 1'b0, 1'b0, 1'b1));
    send_word(command_word(CmdCool));
    send_word(sample_word(16'hffff, 1'b0, 1'b0, 1'b0));
    send_word(sample_word(16'hffff, 1'b0, 1'b0, 1'b1));
    for (int n = 0; n < 40; n++) send_word(random_word(1'b1));
  endtask

  // receiver stall pattern, changing style after each random span
  initial begin
    int unsigned style;
    int unsigned span;
    int unsigned mask;
    @(posedge rst_n);
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(16, 96);
      mask  = $urandom;
      repeat (span) begin
        @(posedge clk);
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom);
          2: begin
            out_ready <= mask[0];
            mask = {mask[0], mask[31:1]};
          end
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got temp %0d", $time, temp_f);
        mismatches++;
      end else begin
        want_r = pending_readings.pop_front();
        check_field("temp_fahrenheit", want_r.temp, temp_f);
        check_field("heater_drive", want_r.drive, heater_drive);
        check_field("heater_pin", want_r.heater, heater_pin);
        check_field("exhaust_fan", want_r.exhaust, exhaust_fan);
        check_field("overtemp", want_r.overtemp, overtemp);
        check_field("fan_timer", want_r.fan_timer, fan_timer);
        check_field("drum_pwm", want_r.drum_pwm, drum_pwm);
        check_field("drum_enable", want_r.drum_on, drum_enable);
        check_field("cooling_mode", want_r.cooling, cooling_mode);
        check_field("roast_finished", want_r.finished, roast_finished);
        check_field("elapsed_seconds", want_r.elapsed, elapsed_seconds);
        check_field("first_crack_seconds", want_r.crack, first_crack_seconds);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no word moved for %0d cycles", $time, StallLimit);
    $display("status: fail");
    $finish;
  end

  // main sequence
  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    mode           <= ModeSample;
    tc_high        <= '0;
    tc_low         <= '0;
    control_due    <= 1'b0;
    second_tick    <= 1'b0;
    cooling_second <= 1'b0;
    cmd0           <= '0;
    cmd1           <= '0;
    cmd2           <= '0;
    cmd3           <= '0;
    out_ready      <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    gain_q         = rtc_pkg::GainReset;
    duration_q     = rtc_pkg::DurationReset;
    setpoint_q     = 450;
    fan_pct_q      = 50;
    drum_speed_q   = 0;
    drum_run_q     = 1'b0;
    cool_q         = 1'b0;
    done_q         = 1'b0;
    over_q         = 1'b0;
    heat_q         = 1'b0;
    exhaust_q      = 1'b0;
    drive_q        = 8'd160;
    elapsed_q      = '0;
    crack_q        = '0;
    mismatches     = 0;
    burst_left     = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_sensor_extremes();
    test_command_decode();
    test_random_phases();
    test_clock_duration();
    test_cooling();

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
rtl/core/rtc_pkg.sv
rtl/core/rtc_cfg.sv
rtl/core/rtc_conv.sv
rtl/core/rtc_ctrl.sv
rtl/core/rtc_out.sv
rtl/core/roaster_temperature_controller_core.sv
rtl/core/rtc_checker.sv
bench/testbench.sv
